FILE: src/lhbp_pkg.sv
// lhbp_pkg: shared constants, types and counter update for the local history predictor
// no dependencies
`default_nettype none

package lhbp_pkg;

    localparam int PC_W                    = 17;
    localparam int LOCAL_INDEX_BITS_DEF    = 14;
    localparam int PATTERN_INDEX_BITS_DEF  = 17;
    localparam int CTR_W                   = 2;

    typedef logic [CTR_W-1:0] ctr_t;

    localparam ctr_t CTR_RESET = 2'd2;
    localparam ctr_t CTR_MAX   = 2'd3;
    localparam ctr_t CTR_MIN   = 2'd0;
    localparam int   HIST_RESET = 2;

    // one saturating step toward the resolved direction
    function automatic ctr_t ctr_step(input ctr_t ctr, input logic dir_taken);
        ctr_t res;
        res = ctr;
        if (dir_taken)
        begin
            if (ctr != CTR_MAX)
                res = ctr + ctr_t'(1);
        end
        else
        begin
            if (ctr != CTR_MIN)
                res = ctr - ctr_t'(1);
        end
        return res;
    endfunction

    // taken when the counter is 2 or 3
    function automatic logic ctr_taken(input ctr_t ctr);
        return ctr[CTR_W-1];
    endfunction

endpackage

`default_nettype wire

FILE: src/local_history_branch_predictor_unit.sv
// local_history_branch_predictor_unit: two-level local history predictor top level
// depends on lhbp_pkg and lhbp_ram
//
//   channel | signals                              | transaction
//   --------+--------------------------------------+---------------------------------
//   in      | in_valid, in_ready, kind, pc, taken  | one predict or update request
//   out     | out_valid, out_ready, predict_taken  | prediction before any update
//
// each transaction runs through a history table read, then a dependent counter table
// read, then the write-back of both tables on an update; one item is in flight at a
// time, so a new item is taken only once the last one is finished; after reset a
// clearing pass writes every entry of both tables, and in_ready stays low meanwhile
// the result sits in an output register; a stalled output holds the item in the
// counter read state, the next item is taken once the result is registered
`default_nettype none

module local_history_branch_predictor_unit
    import lhbp_pkg::*;
#(
    parameter int LOCAL_INDEX_BITS   = LOCAL_INDEX_BITS_DEF,
    parameter int PATTERN_INDEX_BITS = PATTERN_INDEX_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            kind,
    input  wire logic [PC_W-1:0] pc,
    input  wire logic            taken,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 predict_taken
);

    localparam int LW = LOCAL_INDEX_BITS;
    localparam int PW = PATTERN_INDEX_BITS;
    // width that holds pc, history and pattern index alike
    localparam int CW0 = (PC_W > LW) ? PC_W : LW;
    localparam int CW  = (CW0 > PW) ? CW0 : PW;
    // clearing counter spans the larger table
    localparam int CLR_W = (LW > PW) ? LW : PW;
    localparam logic [CW-1:0] LOCAL_MASK = CW'((64'(1) << LW) - 64'(1));
    localparam logic [LW-1:0] HIST_INIT  = LW'(HIST_RESET);

    // state codes
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_HIST  = 2'd2;
    localparam logic [1:0] ST_CTR   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CLR_W-1:0] clear_idx_reg, clear_idx_next;
    logic [PC_W-1:0]  pc_reg;
    logic             kind_reg;
    logic             taken_reg;
    logic [PW-1:0]    pidx_reg;
    logic             out_valid_reg, out_valid_next;
    logic             predict_reg;

    // table ports
    logic          hist_we, hist_re;
    logic [LW-1:0] hist_waddr, hist_raddr, hist_wdata, hist_rdata;
    logic          ctr_we, ctr_re;
    logic [PW-1:0] ctr_waddr, ctr_raddr;
    ctr_t          ctr_wdata, ctr_rdata;

    logic          accept;
    logic          finish;
    logic          clearing;
    logic [CW-1:0] in_pc_ext;
    logic [CW-1:0] pc_reg_ext;
    logic [CW-1:0] pattern_full;
    logic [PW-1:0] pidx;

    assign clearing = (state_reg == ST_CLEAR);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    // the item completes once the output register is free or being emptied
    assign finish   = (state_reg == ST_CTR) && (!out_valid_reg || out_ready);

    // local history index from the incoming pc
    assign in_pc_ext  = CW'(pc);
    assign hist_raddr = in_pc_ext[LW-1:0];
    assign hist_re    = accept;

    // pattern index: upper pc bits joined with the local history
    assign pc_reg_ext   = CW'(pc_reg);
    assign pattern_full = (pc_reg_ext & ~LOCAL_MASK) | CW'(hist_rdata);
    assign pidx         = pattern_full[PW-1:0];
    assign ctr_raddr    = pidx;
    assign ctr_re       = (state_reg == ST_HIST);

    // write-back on an update, or the reset value during the clearing pass
    assign hist_we    = clearing || (finish && kind_reg);
    assign hist_waddr = clearing ? clear_idx_reg[LW-1:0] : pc_reg_ext[LW-1:0];
    assign hist_wdata = clearing ? HIST_INIT : {hist_rdata[LW-2:0], taken_reg};

    assign ctr_we    = clearing || (finish && kind_reg);
    assign ctr_waddr = clearing ? clear_idx_reg[PW-1:0] : pidx_reg;
    assign ctr_wdata = clearing ? CTR_RESET : ctr_step(ctr_rdata, taken_reg);

    lhbp_ram #(
        .WIDTH (LW),
        .DEPTH (2 ** LW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    lhbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (2 ** PW)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_idx_next = clear_idx_reg + CLR_W'(1);
                if (clear_idx_reg == {CLR_W{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_HIST;
            end
            ST_HIST:
            begin
                state_next = ST_CTR;
            end
            ST_CTR:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pc_reg    <= pc;
            kind_reg  <= kind;
            taken_reg <= taken;
        end
        if (ctr_re)
            pidx_reg <= pidx;
        if (finish)
            predict_reg <= ctr_taken(ctr_rdata);
    end

    assign out_valid     = out_valid_reg;
    assign predict_taken = predict_reg;

endmodule

`default_nettype wire

FILE: src/lhbp_ram.sv
// lhbp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lhbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/lhbp_checker.sv
// lhbp_checker: port-level assertions for the local history predictor, bound to the top
// depends on lhbp_pkg and local_history_branch_predictor_unit
`default_nettype none

module lhbp_checker
    import lhbp_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            kind,
    input wire logic [PC_W-1:0] pc,
    input wire logic            taken,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic            predict_taken
);

    logic in_acc;
    logic in_fields_seen;

    assign in_acc         = in_valid && in_ready;
    assign in_fields_seen = kind ^ taken ^ (^pc);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(predict_taken))
        else $error("result changed while stalled");

    // one item in flight: in_ready stays low through the history and counter read states after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready ##1 !in_ready)
        else $error("new transaction taken while busy");

    // with an empty output, the result appears once the item has passed the history and counter read states
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !out_valid |-> ##3 out_valid)
        else $error("result missing after accept");

    // input payload is known when a transaction is taken
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !$isunknown(in_fields_seen))
        else $error("unknown input payload on accept");

endmodule

bind local_history_branch_predictor_unit lhbp_checker u_lhbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .pc            (pc),
    .taken         (taken),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .predict_taken (predict_taken)
);

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking bench for the local history branch predictor unit
// depends on lhbp_pkg and local_history_branch_predictor_unit (with lhbp_ram)
// predicts every transaction with its own copy of both tables and checks each result in order
`timescale 1ns / 100ps

module tb_top;
    import lhbp_pkg::*;

    // request kinds
    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    localparam int HIST_W       = LOCAL_INDEX_BITS_DEF;
    localparam int HIST_ENTRIES = 1 << LOCAL_INDEX_BITS_DEF;
    localparam int CTR_ENTRIES  = 1 << PATTERN_INDEX_BITS_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int MAX_GAP      = 17;
    localparam int POOL_SIZE    = 8;

    // shadow of both tables plus the queue of predictions still owed by the block
    class prediction_checker;
        logic [HIST_W-1:0] history [HIST_ENTRIES];
        ctr_t              counters [CTR_ENTRIES];
        logic              owed [$];
        int errors;
        int checked;
        int n_update;
        int n_predict;
        int pinned_high;
        int pinned_low;

        function new();
            foreach (history[i])
                history[i] = HIST_W'(HIST_RESET);
            foreach (counters[i])
                counters[i] = CTR_RESET;
            errors      = 0;
            checked     = 0;
            n_update    = 0;
            n_predict   = 0;
            pinned_high = 0;
            pinned_low  = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // an accepted request: look up the counter, owe its prediction, then train on an update
        function void note_request(logic k, logic [PC_W-1:0] addr, logic outcome);
            logic [HIST_W-1:0] hist;
            logic [PC_W-1:0]   slot;
            ctr_t              ctr;
            hist = history[addr[HIST_W-1:0]];
            slot = {addr[PC_W-1:HIST_W], hist};
            ctr  = counters[slot];
            owed.push_back(ctr >= 2'd2);
            if (k == KIND_UPDATE)
            begin
                n_update++;
                if (outcome)
                begin
                    if (ctr == CTR_MAX)
                        pinned_high++;
                    else
                        ctr = ctr + 2'd1;
                end
                else
                begin
                    if (ctr == CTR_MIN)
                        pinned_low++;
                    else
                        ctr = ctr - 2'd1;
                end
                counters[slot] = ctr;
                history[addr[HIST_W-1:0]] = {hist[HIST_W-2:0], outcome};
            end
            else
                n_predict++;
        endfunction

        task check_prediction(logic got);
            logic want;
            if (owed.size() == 0)
                report("result transaction with no request outstanding");
            else
            begin
                want = owed.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("predict_taken got %b expected %b", got, want));
            end
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic            kind;
    logic [PC_W-1:0] pc;
    logic            taken;
    logic            out_valid;
    logic            out_ready;
    logic            predict_taken;

    prediction_checker sb;
    bit                calm;    // when set neither side idles
    logic [PC_W-1:0]   pool [POOL_SIZE];

    local_history_branch_predictor_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .pc            (pc),
        .taken         (taken),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .predict_taken (predict_taken)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // one request transaction: optional idle gap, then hold valid until accepted
    task automatic send_item(logic k, logic [PC_W-1:0] addr, logic outcome);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        pc       <= addr;
        taken    <= outcome;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(k, addr, outcome);
    endtask

    // refill the branch pool; from entry 4 on, each entry may at random alias an earlier one in the low pc bits
    task automatic refill_pool();
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            if (i >= 4 && $urandom_range(0, 1))
                pool[i] = {3'($urandom), pool[i-2][HIST_W-1:0]};
            else
                pool[i] = PC_W'($urandom);
        end
    endtask

    // result side: random stalls, check every accepted result transaction
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_prediction(predict_taken);
        end
    end

    // run limit: clearing pass plus worst-case gaps and stalls, several times over
    initial
    begin
        #10_000_000;
        $display("timeout: %0d predictions still owed", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int                 sent;
        int                 len;
        int                 period;
        bit                 paused;
        logic [3:0]         pattern;
        logic [PC_W-1:0]    addr;
        logic               outcome;

        clk      = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = KIND_PREDICT;
        pc       = '0;
        taken    = 1'b0;
        calm     = 1'b0;
        paused   = 1'b0;
        sb       = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: address extremes with the ignored taken bit set and clear
        send_item(KIND_PREDICT, 17'h00000, 1'b1);
        send_item(KIND_PREDICT, 17'h1FFFF, 1'b0);
        send_item(KIND_PREDICT, 17'h03FFF, 1'b1);
        send_item(KIND_PREDICT, 17'h1C000, 1'b0);
        // a not-taken update then a lookup of the same branch
        send_item(KIND_UPDATE, 17'h1FFFF, 1'b0);
        send_item(KIND_PREDICT, 17'h1FFFF, 1'b1);
        // always-taken branch: history fills with ones, then the counter pins at 3
        repeat (16) send_item(KIND_UPDATE, 17'h0A5A5, 1'b1);
        send_item(KIND_PREDICT, 17'h0A5A5, 1'b0);

        // random: mostly branches from a small pool with steady or periodic
        // outcomes, so histories saturate and counters pin; the rest is noise
        refill_pool();
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            if ($urandom_range(0, 15) == 0)
                refill_pool();
            // hold off new requests until the block has drained
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                while (sb.pending() > 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // steady streak
                    addr    = pool[$urandom_range(0, POOL_SIZE-1)];
                    outcome = 1'($urandom);
                    len     = $urandom_range(6, 20);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 5) == 0)
                            send_item(KIND_PREDICT, addr, 1'($urandom));
                        else
                            send_item(KIND_UPDATE, addr, outcome);
                    end
                end
                4, 5, 6:
                begin
                    // periodic loop-like outcome pattern
                    addr    = pool[$urandom_range(0, POOL_SIZE-1)];
                    pattern = 4'($urandom);
                    period  = $urandom_range(2, 4);
                    len     = $urandom_range(8, 24);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 5) == 0)
                            send_item(KIND_PREDICT, addr, 1'($urandom));
                        else
                            send_item(KIND_UPDATE, addr, pattern[i % period]);
                    end
                end
                default:
                begin
                    // unrelated noise
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        send_item(1'($urandom), PC_W'($urandom), 1'($urandom));
                end
            endcase
            sent += len;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d updates and %0d predict-only lookups; %0d results checked",
                 sb.n_update, sb.n_predict, sb.checked);
        $display("counters held at the top %0d times and at the bottom %0d times",
                 sb.pinned_high, sb.pinned_low);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
